// ===== rtl/core/far_pkg.sv =====
// ----------------------------------------------------------------------------
// far_pkg
// Shared types and constants for the condition-flag alias rename table.
// ----------------------------------------------------------------------------
package far_pkg;

    // Width of the alias field on the stream ports
    localparam int ALIAS_W            = 4;
    localparam int DEF_ALIAS_ENTRIES  = 16;

    // Flag entries: bit 6 CF down to bit 0 DF
    localparam int NUM_FLAGS          = 7;
    localparam int ZF_BIT             = 3;
    localparam int SF_BIT             = 2;
    localparam int VALUE_W            = 32;

    // Input tdata layout
    localparam int S_MASK_LSB         = 0;
    localparam int S_REQ_LSB          = S_MASK_LSB + NUM_FLAGS;
    localparam int S_VALUE_LSB        = S_REQ_LSB + ALIAS_W;
    localparam int S_TDATA_W          = 48;

    // Output tdata layout
    localparam int M_GRANT_LSB        = 0;
    localparam int M_ALIAS_LSB        = 1;
    localparam int M_READY_LSB        = M_ALIAS_LSB + ALIAS_W;
    localparam int M_VALUE_LSB        = M_READY_LSB + NUM_FLAGS;
    localparam int M_TDATA_W          = 24;

    typedef enum logic {
        KIND_RENAME    = 1'b0,
        KIND_WRITEBACK = 1'b1
    } kind_t;

    // Pool command: allocate the lowest free alias, or free the named alias
    typedef struct packed {
        logic               alloc_en;
        logic               free_en;
        logic [ALIAS_W-1:0] free_req;
    } pool_cmd_t;

    // Flag table command
    typedef struct packed {
        logic                  rename_en;
        logic [NUM_FLAGS-1:0]  mask;
        logic                  wb_en;
        logic [ALIAS_W-1:0]    wb_req;
        logic                  wb_sign;
        logic                  wb_zero;
    } flag_cmd_t;

endpackage

// ===== rtl/core/flag_alias_rename_table.sv =====
// ----------------------------------------------------------------------------
// flag_alias_rename_table
// Renames condition flags to aliases from a pool and marks them ready on
// writeback of the producing result.
// ----------------------------------------------------------------------------
//  channel  | direction | tdata (low bit up)                           | tuser
//  s_       | in        | flag_mask, alias_req, result_value           | kind
//  m_       | out       | granted, given_alias, ready_bits, value_bits | -
//
//  One item per cycle sustained while m_tready is high; an item passes the input
//  register, then pick, tag compare and state update ahead of the result register.
//  State is updated as an item moves from the input register to the result
//  register, so the next item sees it at once.
//  aresetn is synchronous: all aliases free, all tags, ready and value zero.
//  A stalled m_ side holds the result; the input register keeps taking an
//  item whenever it is empty or moving on.
// ----------------------------------------------------------------------------
module flag_alias_rename_table #(
    parameter int ALIAS_ENTRIES = far_pkg::DEF_ALIAS_ENTRIES
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [far_pkg::S_TDATA_W-1:0] s_tdata,  // flag_mask, alias_req, result_value
    input  logic                          s_tuser,  // kind
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [far_pkg::M_TDATA_W-1:0] m_tdata   // granted, given_alias, ready_bits,
                                                    // value_bits
);

    localparam int TAG_W = $clog2(ALIAS_ENTRIES);
    localparam int CMP_W = (TAG_W > far_pkg::ALIAS_W) ? TAG_W : far_pkg::ALIAS_W;
    localparam int M_USED_W = far_pkg::M_VALUE_LSB + far_pkg::NUM_FLAGS;

    // input register
    logic                             in_valid_reg;
    far_pkg::kind_t                   in_kind_reg;
    logic [far_pkg::NUM_FLAGS-1:0]    in_mask_reg;
    logic [far_pkg::ALIAS_W-1:0]      in_req_reg;
    logic [far_pkg::VALUE_W-1:0]      in_value_reg;

    // result register
    logic                             m_valid_reg;
    logic                             m_granted_reg;
    logic [far_pkg::ALIAS_W-1:0]      m_alias_reg;
    logic [far_pkg::NUM_FLAGS-1:0]    m_ready_reg;
    logic [far_pkg::NUM_FLAGS-1:0]    m_value_reg;

    logic                             advance;
    logic                             s_accept;
    logic                             is_rename;
    far_pkg::pool_cmd_t               pool_cmd;
    far_pkg::flag_cmd_t               flag_cmd;
    logic                             found;
    logic [TAG_W-1:0]                 pick;
    logic [CMP_W-1:0]                 pick_wide;
    logic [far_pkg::NUM_FLAGS-1:0]    ready_next;
    logic [far_pkg::NUM_FLAGS-1:0]    value_next;

    assign advance  = in_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;
    assign is_rename = (in_kind_reg == far_pkg::KIND_RENAME);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_accept) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_kind_reg  <= far_pkg::kind_t'(s_tuser);
            in_mask_reg  <= s_tdata[far_pkg::S_MASK_LSB +: far_pkg::NUM_FLAGS];
            in_req_reg   <= s_tdata[far_pkg::S_REQ_LSB +: far_pkg::ALIAS_W];
            in_value_reg <= s_tdata[far_pkg::S_VALUE_LSB +: far_pkg::VALUE_W];
        end
    end

    always_comb begin
        pool_cmd.alloc_en = advance && is_rename;
        pool_cmd.free_en  = advance && !is_rename;
        pool_cmd.free_req = in_req_reg;
    end

    always_comb begin
        flag_cmd.rename_en = advance && is_rename && found;
        flag_cmd.mask      = in_mask_reg;
        flag_cmd.wb_en     = advance && !is_rename;
        flag_cmd.wb_req    = in_req_reg;
        flag_cmd.wb_sign   = in_value_reg[far_pkg::VALUE_W-1];
        flag_cmd.wb_zero   = (in_value_reg == '0);
    end

    far_alias_pool #(
        .ALIAS_ENTRIES (ALIAS_ENTRIES)
    ) u_pool (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (pool_cmd),
        .found   (found),
        .pick    (pick)
    );

    far_flag_table #(
        .ALIAS_ENTRIES (ALIAS_ENTRIES)
    ) u_flags (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (flag_cmd),
        .new_tag    (pick),
        .ready_next (ready_next),
        .value_next (value_next)
    );

    // report the low alias bits of the tag
    assign pick_wide = CMP_W'(pick);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            m_granted_reg <= !is_rename || found;
            m_alias_reg   <= (is_rename && found) ? pick_wide[far_pkg::ALIAS_W-1:0] : '0;
            m_ready_reg   <= ready_next;
            m_value_reg   <= value_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = far_pkg::M_TDATA_W'({m_value_reg, m_ready_reg, m_alias_reg,
                                           m_granted_reg});

`ifndef ASSERT_OFF
    a_fail_no_alias: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_granted_reg) |-> (m_alias_reg == '0))
        else $error("failed rename reports an alias");
    a_wb_granted: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && !is_rename) |=> (m_valid_reg && m_granted_reg))
        else $error("writeback not reported as granted");
    a_rename_not_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && is_rename && found) |=> ((m_ready_reg & $past(in_mask_reg)) == '0))
        else $error("renamed flag still marked ready");
    a_out_width: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (m_tdata[far_pkg::M_TDATA_W-1:M_USED_W] == '0))
        else $error("result padding not zero");
`endif

endmodule

// ===== rtl/core/far_alias_pool.sv =====
// ----------------------------------------------------------------------------
// far_alias_pool
// Busy marks of the alias pool with a lowest-free priority pick.
// ----------------------------------------------------------------------------
module far_alias_pool #(
    parameter int ALIAS_ENTRIES = far_pkg::DEF_ALIAS_ENTRIES,
    localparam int TAG_W = $clog2(ALIAS_ENTRIES)
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  far_pkg::pool_cmd_t  cmd,
    output logic                found,
    output logic [TAG_W-1:0]    pick
);

    logic [ALIAS_ENTRIES-1:0] busy_reg;
    logic [ALIAS_ENTRIES-1:0] busy_next;
    logic                     free_in_range;
    logic [TAG_W-1:0]         free_idx;

    always_comb begin
        found = 1'b0;
        pick  = '0;
        for (int i = ALIAS_ENTRIES - 1; i >= 0; i--) begin
            if (!busy_reg[i]) begin
                found = 1'b1;
                pick  = TAG_W'(i);
            end
        end
    end

    assign free_in_range = 32'(cmd.free_req) < 32'(ALIAS_ENTRIES);
    assign free_idx      = TAG_W'(cmd.free_req);

    always_comb begin
        busy_next = busy_reg;
        if (cmd.alloc_en && found) begin
            busy_next[pick] = 1'b1;
        end
        // aliases beyond the pool free nothing
        if (cmd.free_en && free_in_range) begin
            busy_next[free_idx] = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= '0;
        end else begin
            busy_reg <= busy_next;
        end
    end

`ifndef ASSERT_OFF
    a_pick_is_free: assert property (@(posedge aclk) disable iff (!aresetn)
        found |-> !busy_reg[pick])
        else $error("picked alias is busy");
    a_alloc_marks: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.alloc_en && found && !cmd.free_en) |=> busy_reg[$past(pick)])
        else $error("allocated alias not marked busy");
    a_empty_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !found |-> (busy_reg == {ALIAS_ENTRIES{1'b1}}))
        else $error("pool reported empty with a free alias");
`endif

endmodule

// ===== rtl/core/far_flag_table.sv =====
// ----------------------------------------------------------------------------
// far_flag_table
// Per-flag alias tags, ready marks and stored values.
// ----------------------------------------------------------------------------
module far_flag_table #(
    parameter int ALIAS_ENTRIES = far_pkg::DEF_ALIAS_ENTRIES,
    localparam int TAG_W = $clog2(ALIAS_ENTRIES)
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  far_pkg::flag_cmd_t                cmd,
    input  logic [TAG_W-1:0]                  new_tag,
    output logic [far_pkg::NUM_FLAGS-1:0]     ready_next,
    output logic [far_pkg::NUM_FLAGS-1:0]     value_next
);

    localparam int CMP_W = (TAG_W > far_pkg::ALIAS_W) ? TAG_W : far_pkg::ALIAS_W;

    logic [TAG_W-1:0]               tag_reg [far_pkg::NUM_FLAGS];
    logic [TAG_W-1:0]               tag_next [far_pkg::NUM_FLAGS];
    logic [far_pkg::NUM_FLAGS-1:0]  ready_reg;
    logic [far_pkg::NUM_FLAGS-1:0]  value_reg;
    logic [far_pkg::NUM_FLAGS-1:0]  hit;

    always_comb begin
        for (int b = 0; b < far_pkg::NUM_FLAGS; b++) begin
            hit[b] = CMP_W'(tag_reg[b]) == CMP_W'(cmd.wb_req);
        end
    end

    always_comb begin
        tag_next   = tag_reg;
        ready_next = ready_reg;
        value_next = value_reg;
        if (cmd.rename_en) begin
            for (int b = 0; b < far_pkg::NUM_FLAGS; b++) begin
                if (cmd.mask[b]) begin
                    tag_next[b]   = new_tag;
                    ready_next[b] = 1'b0;
                end
            end
        end else if (cmd.wb_en) begin
            ready_next = ready_reg | hit;
            if (hit[far_pkg::SF_BIT]) begin
                value_next[far_pkg::SF_BIT] = cmd.wb_sign;
            end
            if (hit[far_pkg::ZF_BIT]) begin
                value_next[far_pkg::ZF_BIT] = cmd.wb_zero;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int b = 0; b < far_pkg::NUM_FLAGS; b++) begin
                tag_reg[b] <= '0;
            end
            ready_reg <= '0;
            value_reg <= '0;
        end else begin
            tag_reg   <= tag_next;
            ready_reg <= ready_next;
            value_reg <= value_next;
        end
    end

endmodule
